### design/fflia_pkg.sv
package fflia_pkg;

    // Pool geometry
    localparam int POOL_SIZE = 512;
    localparam int IDX_W     = 9;
    localparam int PTR_W     = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
    localparam int CNT_W     = $clog2(POOL_SIZE + 1);

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_POOL_FULL = 2'd1,
        ST_DROPPED   = 2'd2
    } status_t;

    // Request action codes
    typedef enum logic {
        ACT_ALLOC = 1'b0,
        ACT_FREE  = 1'b1
    } action_t;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;
        logic exec;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;
    } stat_t;

endpackage

### design/fflia_req_if.sv
interface fflia_req_if;
    import fflia_pkg::*;

    logic             valid;
    logic             ready;
    logic             action;
    logic [IDX_W-1:0] free_index;

    modport source (output valid, output action, output free_index, input ready);
    modport sink   (input valid, input action, input free_index, output ready);

endinterface

### design/fflia_rsp_if.sv
interface fflia_rsp_if;
    import fflia_pkg::*;

    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] slot_index;
    logic [1:0]       status;
    logic             can_allocate;

    modport source (output valid, output slot_index, output status, output can_allocate,
                    input ready);
    modport sink   (input valid, input slot_index, input status, input can_allocate,
                    output ready);

endinterface

### design/fifo_free_list_index_allocator_core.sv
// A request beat is latched at its accept edge; its result beat is loaded at the end of the EXEC state that follows.
// Requests are not overlapped: the released-index memory is read into a register at the accept
// edge, and the pointers and counters are updated at the end of the EXEC state after it.
// Reset (rst_n low, asynchronous) clears the queue pointers, count, fresh counter,
// controller state and result valid; queue contents stay undefined, with no clearing pass.
module fifo_free_list_index_allocator_core (
    input  logic        clk,
    input  logic        rst_n,
    fflia_req_if.sink   req,
    fflia_rsp_if.source rsp
);
    import fflia_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // Sequence each request
    fflia_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Queue, counters and result register
    fflia_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .in_action     (req.action),
        .in_free_index (req.free_index),
        .rsp           (rsp)
    );

endmodule

### design/fflia_ctrl.sv
module fflia_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  fflia_pkg::stat_t stat,
    output fflia_pkg::cmd_t  cmd
);
    import fflia_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Take a beat only when idle and the result register can be loaded next cycle
    assign in_ready   = (state_reg == S_IDLE) && stat.out_free;
    assign cmd.accept = in_valid && in_ready;
    assign cmd.exec   = (state_reg == S_EXEC);

    // Advance: idle -> exec on accept, exec -> idle always
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### design/fflia_dp.sv
module fflia_dp (
    input  logic                    clk,
    input  logic                    rst_n,
    input  fflia_pkg::cmd_t         cmd,
    output fflia_pkg::stat_t        stat,
    input  logic                    in_action,
    input  logic [fflia_pkg::IDX_W-1:0] in_free_index,
    fflia_rsp_if.source             rsp
);
    import fflia_pkg::*;

    // Released-index ring buffer
    logic [IDX_W-1:0] mem [POOL_SIZE];
    logic [IDX_W-1:0] rd_data_reg;

    // Queue pointers and counters
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] fresh_reg, fresh_next;

    // Latched request
    logic             act_reg;
    logic [IDX_W-1:0] idx_reg;

    // Result register
    logic             out_valid_reg;
    logic [IDX_W-1:0] slot_reg, slot_next;
    status_t          status_reg, status_next;
    logic             can_reg, can_next;
    logic             wr_en;

    assign stat.out_free = !out_valid_reg || rsp.ready;

    // Capture the request and read the queue head at the accept edge
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            act_reg     <= in_action;
            idx_reg     <= in_free_index;
            rd_data_reg <= mem[head_reg];
        end
    end

    // Work out the step's result and next state
    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        fresh_next  = fresh_reg;
        slot_next   = '0;
        status_next = ST_OK;
        wr_en       = 1'b0;
        if (act_reg == ACT_ALLOC)
        begin
            if (count_reg != '0)
            begin
                slot_next  = rd_data_reg;
                head_next  = (32'(head_reg) == POOL_SIZE - 1) ? '0 : head_reg + 1'b1;
                count_next = count_reg - 1'b1;
            end
            else if (32'(fresh_reg) < POOL_SIZE)
            begin
                slot_next  = IDX_W'(fresh_reg);
                fresh_next = fresh_reg + 1'b1;
            end
            else
            begin
                status_next = ST_POOL_FULL;
            end
        end
        else
        begin
            if (32'(idx_reg) < POOL_SIZE)
            begin
                if (32'(count_reg) >= POOL_SIZE)
                begin
                    status_next = ST_DROPPED;
                end
                else
                begin
                    wr_en      = 1'b1;
                    tail_next  = (32'(tail_reg) == POOL_SIZE - 1) ? '0 : tail_reg + 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
        end
        can_next = (32'(fresh_next) < POOL_SIZE) || (count_next != '0);
    end

    // Append a freed index at the tail
    always_ff @(posedge clk)
    begin
        if (cmd.exec && wr_en)
        begin
            mem[tail_reg] <= idx_reg;
        end
    end

    // Commit pointers and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            fresh_reg <= '0;
        end
        else if (cmd.exec)
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            fresh_reg <= fresh_next;
        end
    end

    // Hold the result beat until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.exec)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            slot_reg   <= slot_next;
            status_reg <= status_next;
            can_reg    <= can_next;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.slot_index   = slot_reg;
    assign rsp.status       = status_reg;
    assign rsp.can_allocate = can_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= POOL_SIZE)
        else $error("queue count above pool size");

    a_fresh_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(fresh_reg) <= POOL_SIZE)
        else $error("fresh counter above pool size");

    a_exec_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |-> !out_valid_reg)
        else $error("result overwritten before taken");

    a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status != ST_OK) |-> (rsp.slot_index == '0))
        else $error("failed request carries nonzero slot");

    a_full_cant: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status == ST_POOL_FULL) |-> !rsp.can_allocate)
        else $error("pool full but allocation reported possible");
`endif

endmodule

### tb/fifo_free_list_index_allocator_core_tb.sv
module fifo_free_list_index_allocator_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fflia_pkg::*;

    // One request beat as queued for the driver
    typedef struct {
        action_t          act;
        logic [IDX_W-1:0] idx;
        bit               drain_first;
    } slot_req_t;

    // One predicted result beat
    typedef struct {
        logic [IDX_W-1:0] slot;
        status_t          st;
        logic             can_alloc;
    } slot_grant_t;

    logic clk = 1'b0;
    logic rst_n;

    fflia_req_if req_bus ();
    fflia_rsp_if rsp_bus ();

    fifo_free_list_index_allocator_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus.sink),
        .rsp   (rsp_bus.source)
    );

    // Request queue fed by the stimulus block, expected grants fed by the driver
    slot_req_t   pending_reqs [$];
    slot_grant_t grant_expect [$];

    // Predictor state: released-index ring plus bump counter
    logic [IDX_W-1:0] freed_ring [0:POOL_SIZE-1];
    int unsigned      ring_rd = 0;
    int unsigned      ring_wr = 0;
    int unsigned      ring_fill = 0;
    int unsigned      fresh_next = 0;

    // Handshake bookkeeping
    int unsigned req_taken;
    int unsigned rsp_seen;
    int          burst_left;
    int          gap_left;
    logic [15:0] stall_pat;
    logic [3:0]  pat_pos;
    int          pat_life;

    // Run statistics
    int err_count = 0;
    int n_alloc = 0;
    int n_free = 0;
    int n_ok = 0;
    int n_full = 0;
    int n_dropped = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Advance the predictor by one accepted request and return its grant
    function automatic slot_grant_t predict_grant(action_t act, logic [IDX_W-1:0] idx);
        slot_grant_t g;
        g.slot = '0;
        g.st   = ST_OK;
        if (act == ACT_ALLOC)
        begin
            if (ring_fill != 0)
            begin
                g.slot    = freed_ring[ring_rd];
                ring_rd   = (ring_rd + 1) % POOL_SIZE;
                ring_fill = ring_fill - 1;
            end
            else if (fresh_next < POOL_SIZE)
            begin
                g.slot     = fresh_next[IDX_W-1:0];
                fresh_next = fresh_next + 1;
            end
            else
                g.st = ST_POOL_FULL;
        end
        // Every 9-bit index lies inside the pool, so a free is either queued or dropped
        else if (ring_fill >= POOL_SIZE)
            g.st = ST_DROPPED;
        else
        begin
            freed_ring[ring_wr] = idx;
            ring_wr   = (ring_wr + 1) % POOL_SIZE;
            ring_fill = ring_fill + 1;
        end
        g.can_alloc = (fresh_next < POOL_SIZE) || (ring_fill != 0);
        return g;
    endfunction

    function automatic void queue_req(action_t act, logic [IDX_W-1:0] idx, bit drain_first);
        slot_req_t r;
        r.act         = act;
        r.idx         = idx;
        r.drain_first = drain_first;
        pending_reqs.insert(pending_reqs.size(), r);
    endfunction

    function automatic void flag_mismatch(string msg);
        err_count++;
        if (err_count <= 10)
            $display("[%0t] MISMATCH %s", $time, msg);
    endfunction

    // Request driver: bursts with random gaps, optional drain before a beat
    always @(posedge clk or negedge rst_n)
    begin
        logic        take;
        int          outstanding;
        slot_grant_t g;
        if (!rst_n)
        begin
            req_bus.valid      <= 1'b0;
            req_bus.action     <= ACT_ALLOC;
            req_bus.free_index <= '0;
            req_taken          <= 0;
            burst_left         <= 0;
            gap_left           <= 0;
        end
        else
        begin
            take        = req_bus.valid && req_bus.ready;
            outstanding = req_taken + (take ? 1 : 0) - rsp_seen;
            if (take)
            begin
                g = predict_grant(action_t'(req_bus.action), req_bus.free_index);
                grant_expect.insert(grant_expect.size(), g);
                req_taken <= req_taken + 1;
                if (req_bus.action == ACT_ALLOC)
                    n_alloc++;
                else
                    n_free++;
            end
            if (!req_bus.valid || take)
            begin
                if (gap_left != 0 || pending_reqs.size() == 0
                    || (pending_reqs[0].drain_first && outstanding != 0))
                begin
                    req_bus.valid <= 1'b0;
                    if (gap_left != 0)
                        gap_left <= gap_left - 1;
                end
                else
                begin
                    req_bus.valid      <= 1'b1;
                    req_bus.action     <= pending_reqs[0].act;
                    req_bus.free_index <= pending_reqs[0].idx;
                    pending_reqs.delete(0);
                    // Close the burst and pick the next gap and burst length
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, ($urandom_range(0, 4) == 0) ? 80 : 16);
                        gap_left   <= $urandom_range(0, 6);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
            end
        end
    end

    // Result ready: a 16-bit stall pattern, stepped through bit by bit, that changes now and then
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_bus.ready <= 1'b0;
            stall_pat     <= '1;
            pat_pos       <= '0;
            pat_life      <= 0;
        end
        else
        begin
            rsp_bus.ready <= stall_pat[pat_pos];
            pat_pos       <= pat_pos + 1'b1;
            if (pat_life == 0)
            begin
                pat_life  <= $urandom_range(50, 400);
                stall_pat <= ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                         : (16'($urandom) | 16'h0101);
            end
            else
                pat_life <= pat_life - 1;
        end
    end

    // Result monitor: compare each beat with the oldest expected grant
    always @(posedge clk or negedge rst_n)
    begin
        slot_grant_t want;
        if (!rst_n)
            rsp_seen <= 0;
        else if (rsp_bus.valid && rsp_bus.ready)
        begin
            rsp_seen <= rsp_seen + 1;
            case (rsp_bus.status)
                ST_OK:        n_ok++;
                ST_POOL_FULL: n_full++;
                ST_DROPPED:   n_dropped++;
                default:      ;
            endcase
            if (grant_expect.size() == 0)
                flag_mismatch($sformatf("unexpected result: slot %0d status %0d can_allocate %0b",
                                        rsp_bus.slot_index, rsp_bus.status,
                                        rsp_bus.can_allocate));
            else
            begin
                want = grant_expect[0];
                grant_expect.delete(0);
                if (rsp_bus.slot_index !== want.slot || rsp_bus.status !== want.st
                    || rsp_bus.can_allocate !== want.can_alloc)
                    flag_mismatch($sformatf({"slot exp %0d got %0d, status exp %0d got %0d, ",
                                             "can_allocate exp %0b got %0b"},
                                            want.slot, rsp_bus.slot_index,
                                            want.st, rsp_bus.status,
                                            want.can_alloc, rsp_bus.can_allocate));
            end
        end
    end

    // Stimulus, reset and end of run
    initial
    begin
        int n;
        rst_n = 1'b0;

        // Directed: fresh grants, frees at the index extremes, reuse order, double free
        queue_req(ACT_ALLOC, 9'h000, 1'b0);
        queue_req(ACT_ALLOC, 9'h000, 1'b0);
        queue_req(ACT_ALLOC, 9'h000, 1'b0);
        queue_req(ACT_FREE,  9'h1FF, 1'b0);
        queue_req(ACT_FREE,  9'h000, 1'b0);
        queue_req(ACT_FREE,  9'h155, 1'b0);
        queue_req(ACT_FREE,  9'h0AA, 1'b0);
        queue_req(ACT_ALLOC, 9'h000, 1'b0);
        queue_req(ACT_ALLOC, 9'h000, 1'b0);
        queue_req(ACT_FREE,  9'h003, 1'b0);
        queue_req(ACT_FREE,  9'h003, 1'b0);
        queue_req(ACT_ALLOC, 9'h000, 1'b0);
        queue_req(ACT_ALLOC, 9'h000, 1'b0);
        queue_req(ACT_ALLOC, 9'h000, 1'b0);
        queue_req(ACT_ALLOC, 9'h000, 1'b0);
        queue_req(ACT_ALLOC, 9'h1FF, 1'b0);
        queue_req(ACT_ALLOC, 9'h0AA, 1'b0);
        queue_req(ACT_ALLOC, 9'h155, 1'b0);

        // Allocate-heavy: run the bump counter dry, then hit pool full
        n = 0;
        queue_req(ACT_ALLOC, 9'($urandom), 1'b1);
        while (n < 570)
        begin
            if ($urandom_range(0, 99) < 3)
                queue_req(ACT_FREE, 9'($urandom), 1'b0);
            else
            begin
                queue_req(ACT_ALLOC, 9'($urandom), 1'b0);
                n++;
            end
        end

        // Free-heavy: refill the released queue after the pool ran dry
        n = 0;
        queue_req(ACT_FREE, 9'($urandom), 1'b1);
        while (n < 180)
        begin
            if ($urandom_range(0, 99) < 3)
                queue_req(ACT_ALLOC, 9'($urandom), 1'b0);
            else
            begin
                queue_req(ACT_FREE, 9'($urandom), 1'b0);
                n++;
            end
        end

        // Mixed traffic, drifting the queue back down
        queue_req(ACT_ALLOC, 9'($urandom), 1'b1);
        for (int i = 0; i < 50; i++)
        begin
            if ($urandom_range(0, 99) < 70)
                queue_req(ACT_ALLOC, 9'($urandom), 1'b0);
            else
                queue_req(ACT_FREE, 9'($urandom), 1'b0);
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for every request to go out and every result to come back
        @(negedge clk);
        while (pending_reqs.size() != 0 || req_bus.valid || req_taken != rsp_seen)
            @(negedge clk);
        repeat (10) @(negedge clk);
        if (grant_expect.size() != 0)
            flag_mismatch($sformatf("%0d expected results never arrived", grant_expect.size()));

        $display("Sent %0d requests: %0d allocate, %0d free", n_alloc + n_free, n_alloc, n_free);
        $display("Results: %0d ok, %0d pool full, %0d free dropped; %0d mismatches",
                 n_ok, n_full, n_dropped, err_count);
        if (err_count == 0)
            $display("fifo_free_list_index_allocator_core regression: pass");
        else
            $display("fifo_free_list_index_allocator_core regression: fail");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("Timeout waiting for results");
        $display("fifo_free_list_index_allocator_core regression: fail");
        $finish;
    end

endmodule
